// ----- hdl/selected_line_byte_filter_macros.svh -----
// Assertion helpers for the line filter.
`ifndef SELECTED_LINE_BYTE_FILTER_MACROS_SVH
`define SELECTED_LINE_BYTE_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/slbf_pkg.sv -----
`timescale 1ns / 1ps
package slbf_pkg;

    localparam int LINE_W = 31;
    localparam int BYTE_W = 8;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_DATA    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    // broadcast to every cell
    typedef struct packed {
        logic              go;
        cmd_t              cmd;
        logic [LINE_W-1:0] line_number;
        logic [LINE_W-1:0] line_counter;
    } slbf_ctl_t;

    // handed from one cell to the next one up
    typedef struct packed {
        logic [LINE_W-1:0] value;
        logic              valid;
        logic              lt;
        logic              dup;
        logic              hand;
    } slbf_link_t;

    typedef struct packed {
        logic valid;
        logic ptr;
        logic match;
    } slbf_stat_t;

endpackage

// ----- hdl/slbf_if.sv -----
`timescale 1ns / 1ps
interface slbf_in_if;
    logic                         valid;
    logic                         ready;
    slbf_pkg::cmd_t               cmd;
    logic [slbf_pkg::LINE_W-1:0]  line_number;
    logic [slbf_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output cmd, output line_number, output data_byte,
                    input ready);
    modport sink   (input valid, input cmd, input line_number, input data_byte,
                    output ready);
endinterface

interface slbf_out_if;
    logic                         valid;
    logic                         ready;
    logic [slbf_pkg::BYTE_W-1:0]  out_byte;
    logic [slbf_pkg::LINE_W-1:0]  out_line;

    modport source (output valid, output out_byte, output out_line, input ready);
    modport sink   (input valid, input out_byte, input out_line, output ready);
endinterface

// ----- hdl/slbf_cell.sv -----
`timescale 1ns / 1ps
module slbf_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slbf_pkg::slbf_ctl_t  ctl,
    input  slbf_pkg::slbf_link_t left,
    output slbf_pkg::slbf_link_t right,
    output slbf_pkg::slbf_stat_t stat
);
    import slbf_pkg::*;

    logic [LINE_W-1:0] value_reg, value_next;
    logic              valid_reg, valid_next;
    logic              ptr_reg, ptr_next;

    logic lt, eq, is_pos, dup_here, adv, here;

    always_comb
    begin
        lt       = valid_reg && (value_reg < ctl.line_number);
        eq       = valid_reg && (value_reg == ctl.line_number);
        // first cell not below the new number is where it lands
        is_pos   = !lt && left.lt;
        // a duplicate found at the landing cell blocks the shift above it
        dup_here = is_pos ? eq : left.dup;
        adv      = ptr_reg && valid_reg && (ctl.line_counter > value_reg);
        here     = (ptr_reg && !adv) || left.hand;
    end

    always_comb
    begin
        right.value = value_reg;
        right.valid = valid_reg;
        right.lt    = lt;
        right.dup   = dup_here;
        right.hand  = adv;
        stat.valid  = valid_reg;
        stat.ptr    = ptr_reg;
        stat.match  = here && valid_reg && (value_reg == ctl.line_counter);
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (ctl.go)
        begin
            unique case (ctl.cmd)
                CMD_CLEAR:
                begin
                    valid_next = 1'b0;
                    ptr_next   = IS_HEAD;
                end
                CMD_INSERT:
                begin
                    if ((ctl.line_number != '0) && !lt && !dup_here)
                    begin
                        value_next = is_pos ? ctl.line_number : left.value;
                        valid_next = is_pos || left.valid;
                    end
                end
                CMD_DATA:
                begin
                    ptr_next = here;
                end
                CMD_RESTART:
                begin
                    ptr_next = IS_HEAD;
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ptr_reg   <= IS_HEAD;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- hdl/selected_line_byte_filter.sv -----
// Selected line byte filter.
// in_ch carries requests: cmd, line_number, data_byte. Clear empties the
// table and rewinds the stream; insert adds a line number to the sorted
// table (zero and duplicates ignored, largest entry dropped when full);
// data counts a text byte into lines; restart rewinds the stream only.
// out_ch carries one request per passed byte: out_byte and its out_line.
// A data request whose line is the current table entry produces a result
// in the output register in the cycle after acceptance.
// Throughput is one request per cycle while in_ch.ready is high: every table
// cell compares and shifts in the same cycle, the stream pointer is a token
// that moves at most one cell per byte.
// in_ch.ready is low only while a result sits in the output register and
// out_ch.ready is low; a stalled receiver holds the result steady.
// Reset: table empty, pointer at the first cell, line counter at one,
// no result pending. No clearing pass is needed.
`timescale 1ns / 1ps
module selected_line_byte_filter #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    slbf_in_if.sink       in_ch,
    slbf_out_if.source    out_ch
);
    import slbf_pkg::*;

    `include "selected_line_byte_filter_macros.svh"

    slbf_ctl_t               ctl;
    slbf_link_t              links [TABLE_DEPTH+1];
    slbf_stat_t              stats [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_vec, ptr_vec, match_vec;

    logic [LINE_W-1:0] line_counter_reg, line_counter_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [LINE_W-1:0] out_line_reg, out_line_next;
    logic              go, hit, non_data_go;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign go          = in_ch.valid && in_ch.ready;
    assign non_data_go = go && (in_ch.cmd != CMD_DATA);

    always_comb
    begin
        ctl.go           = go;
        ctl.cmd          = in_ch.cmd;
        ctl.line_number  = in_ch.line_number;
        ctl.line_counter = line_counter_reg;
    end

    // boundary below the first cell: everything is "less than" here
    always_comb
    begin
        links[0].value = '0;
        links[0].valid = 1'b0;
        links[0].lt    = 1'b1;
        links[0].dup   = 1'b0;
        links[0].hand  = 1'b0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        slbf_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .left  (links[i]),
            .right (links[i+1]),
            .stat  (stats[i])
        );
        assign valid_vec[i] = stats[i].valid;
        assign ptr_vec[i]   = stats[i].ptr;
        assign match_vec[i] = stats[i].match;
    end

    assign hit = |match_vec;

    always_comb
    begin
        line_counter_next = line_counter_reg;
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_line_next     = out_line_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (go)
        begin
            unique case (in_ch.cmd)
                CMD_CLEAR, CMD_RESTART:
                begin
                    line_counter_next = LINE_W'(1);
                end
                CMD_DATA:
                begin
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = in_ch.data_byte;
                        out_line_next  = line_counter_reg;
                    end
                    if ((in_ch.data_byte == NEWLINE) && (line_counter_reg != LINE_MAX))
                    begin
                        line_counter_next = line_counter_reg + LINE_W'(1);
                    end
                end
                CMD_INSERT:
                begin
                    line_counter_next = line_counter_reg;
                end
                default:
                begin
                    line_counter_next = line_counter_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_counter_reg <= LINE_W'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            line_counter_reg <= line_counter_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_line_reg <= out_line_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_line = out_line_reg;

    `SLBF_ASSERT_NOW(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "table holes")
    `SLBF_ASSERT_NOW(a_one_token, 1'b1, $onehot0(ptr_vec), "more than one stream pointer")
    `SLBF_ASSERT_NEXT(a_result_only_data, non_data_go, !$rose(out_valid_reg), "stray result")
    `SLBF_ASSERT_NOW(a_counter_nonzero, 1'b1, line_counter_reg != '0, "line counter at zero")

endmodule
